>>> sv/c3rgb_pkg.sv
// Package for the 3x3 RGB convolution filter: pixel, window and result types,
// configuration register indexes and fixed arithmetic constants.
// No dependencies.
package c3rgb_pkg;

    localparam int PIX_BITS   = 8;
    localparam int RGB_BITS   = 3 * PIX_BITS;
    localparam int FRAC_BITS  = 12;
    localparam int COEF_FIELD = 16;
    localparam int COEF_REG_W = 48;
    localparam int IMG_W_BITS = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [COEF_REG_W-1:0] COEF_TOP_RST = 48'h0000_0000_0000;
    localparam logic [COEF_REG_W-1:0] COEF_MID_RST = 48'h0000_1000_0000;
    localparam logic [COEF_REG_W-1:0] COEF_BOT_RST = 48'h0000_0000_0000;
    localparam logic [IMG_W_BITS-1:0] IMG_W_RST    = 12'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TOP = 3'd0,
        CFG_COEF_MID = 3'd1,
        CFG_COEF_BOT = 3'd2,
        CFG_IMG_W    = 3'd3,
        CFG_GREY     = 3'd4
    } t_cfg_idx;

    typedef logic [RGB_BITS-1:0] t_pix;

    // 3x3 neighborhood, index row*3+col, row 0 oldest, col 0 leftmost
    typedef struct packed {
        logic       vld;
        logic       eor;
        t_pix [8:0] pix;
    } t_view_bus;

    typedef struct packed {
        logic                vld;
        logic                eor;
        logic [PIX_BITS-1:0] blue;
        logic [PIX_BITS-1:0] green;
        logic [PIX_BITS-1:0] red;
    } t_res;

endpackage

>>> sv/c3rgb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered,
// read-before-write output. No dependencies.
module c3rgb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/c3rgb_line_buf.sv
// Position counters, two-row line store (one RAM, read-modify-write per pixel)
// and the 3x3 window with zero padding. Depends on c3rgb_pkg and c3rgb_ram.
module c3rgb_line_buf #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_accept,
    input  logic                                i_req_type,
    input  logic                                i_sof,
    input  logic [c3rgb_pkg::PIX_BITS-1:0]      i_red,
    input  logic [c3rgb_pkg::PIX_BITS-1:0]      i_green,
    input  logic [c3rgb_pkg::PIX_BITS-1:0]      i_blue,
    input  logic [c3rgb_pkg::IMG_W_BITS-1:0]    i_image_width,
    input  logic                                i_grey,
    output c3rgb_pkg::t_view_bus                o_view
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int IW   = $clog2(MAX_WIDTH + 2);
    localparam int CMPW = (WW > c3rgb_pkg::IMG_W_BITS) ? WW : c3rgb_pkg::IMG_W_BITS;
    localparam int PW   = c3rgb_pkg::RGB_BITS;

    // Counters; the row count only needs to know "at least one" and "at least two".
    logic [WW-1:0] r_col;
    logic [1:0]    r_row;
    logic [IW-1:0] r_seen;

    logic [CMPW-1:0] w_ext;
    logic [WW-1:0]   w;
    logic [WW-1:0]   cc;
    logic [1:0]      rc;
    logic [IW-1:0]   seen;
    logic [IW-1:0]   w_p1;
    logic            wrap;
    logic [WW-1:0]   c;
    logic [1:0]      r;
    logic            outv;
    logic [PW-1:0]   cur;

    always_comb begin
        w_ext = CMPW'(i_image_width);
        if (w_ext == '0) begin
            w_ext = CMPW'(1);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            w_ext = CMPW'(MAX_WIDTH);
        end
        w = w_ext[WW-1:0];

        cc   = i_sof ? '0 : r_col;
        rc   = i_sof ? '0 : r_row;
        seen = i_sof ? '0 : r_seen;
        wrap = (cc >= w);
        c    = wrap ? '0 : cc;
        if (wrap) begin
            r = (rc == 2'd2) ? 2'd2 : rc + 2'd1;
        end else begin
            r = rc;
        end
        w_p1 = IW'(w) + IW'(1);
        outv = (seen >= w_p1);

        if (i_req_type) begin
            cur = '0;
        end else if (i_grey) begin
            cur = {{(PW - c3rgb_pkg::PIX_BITS){1'b0}}, i_red};
        end else begin
            cur = {i_blue, i_green, i_red};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_seen <= '0;
        end else if (i_accept) begin
            r_col  <= c + WW'(1);
            r_row  <= r;
            r_seen <= outv ? seen : seen + IW'(1);
        end
    end

    // Stage 1: RAM data arrives; line store word is {older row, newer row}.
    logic            r1_v;
    logic            r1_fwd;
    logic [2*PW-1:0] r1_fwd_word;
    logic [PW-1:0]   r1_cur;
    logic [AW-1:0]   r1_addr;
    logic            r1_rge1;
    logic            r1_rge2;
    logic            r1_c0;
    logic            r1_c1;
    logic            r1_w1;
    logic            r1_outv;

    logic [2*PW-1:0] rd_word;
    logic [2*PW-1:0] old_word;
    logic [2*PW-1:0] wr_word;
    logic [AW-1:0]   rd_addr;
    logic [PW-1:0]   top;
    logic [PW-1:0]   mid;

    assign rd_addr = c[AW-1:0];

    c3rgb_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_en & r1_v),
        .i_wr_addr (r1_addr),
        .i_wr_data (wr_word),
        .i_rd_en   (i_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

    always_comb begin
        // A read that met the write of the item ahead at the same entry sees old data.
        old_word = r1_fwd ? r1_fwd_word : rd_word;
        wr_word  = {old_word[PW-1:0], r1_cur};
        top      = r1_rge2 ? old_word[2*PW-1:PW] : '0;
        mid      = r1_rge1 ? old_word[PW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r1_fwd <= 1'b0;
        end else if (i_en) begin
            r1_v   <= i_accept;
            r1_fwd <= r1_v && (r1_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_fwd_word <= wr_word;
            r1_cur      <= cur;
            r1_addr     <= rd_addr;
            r1_rge1     <= (r != 2'd0);
            r1_rge2     <= (r == 2'd2);
            r1_c0       <= (c == '0);
            r1_c1       <= (c == WW'(1));
            r1_w1       <= (w == WW'(1));
            r1_outv     <= outv;
        end
    end

    // Window and padded view.
    c3rgb_pkg::t_pix [8:0] r_win;
    c3rgb_pkg::t_pix [8:0] nxt_win;
    c3rgb_pkg::t_pix [8:0] view;
    c3rgb_pkg::t_pix [2:0] col_in;

    always_comb begin
        col_in[0] = top;
        col_in[1] = mid;
        col_in[2] = r1_cur;
        for (int i = 0; i < 3; i++) begin
            nxt_win[i*3+0] = r_win[i*3+1];
            nxt_win[i*3+1] = r_win[i*3+2];
            nxt_win[i*3+2] = col_in[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (r1_c0) begin
                view[i*3+0] = r1_w1 ? '0 : r_win[i*3+1];
                view[i*3+1] = r_win[i*3+2];
                view[i*3+2] = '0;
            end else begin
                view[i*3+0] = r1_c1 ? '0 : nxt_win[i*3+0];
                view[i*3+1] = nxt_win[i*3+1];
                view[i*3+2] = nxt_win[i*3+2];
            end
        end
    end

    c3rgb_pkg::t_view_bus r2_view;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r2_view.vld <= 1'b0;
        end else if (i_en) begin
            if (r1_v) begin
                r_win <= nxt_win;
            end
            r2_view.vld <= r1_v & r1_outv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_view.eor <= r1_c0;
            r2_view.pix <= view;
        end
    end

    assign o_view = r2_view;

endmodule

>>> sv/c3rgb_mac.sv
// Weighted sum of the 3x3 view per channel: products, row sums, final sum and
// clamp to 0..255. Depends on c3rgb_pkg.
module c3rgb_mac #(
    parameter int COEF_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  c3rgb_pkg::t_view_bus                 i_view,
    input  logic [c3rgb_pkg::COEF_REG_W-1:0]     i_coef_top,
    input  logic [c3rgb_pkg::COEF_REG_W-1:0]     i_coef_mid,
    input  logic [c3rgb_pkg::COEF_REG_W-1:0]     i_coef_bot,
    input  logic                                 i_grey,
    output c3rgb_pkg::t_res                      o_res
);

    localparam int PB  = c3rgb_pkg::PIX_BITS;
    localparam int PW  = COEF_BITS + PB + 1;
    localparam int RW  = PW + 2;
    localparam int SWA = PW + 4;
    localparam int SWB = c3rgb_pkg::FRAC_BITS + PB + 2;
    localparam int SW  = (SWA > SWB) ? SWA : SWB;
    localparam int FB  = c3rgb_pkg::FRAC_BITS;

    logic [c3rgb_pkg::COEF_REG_W-1:0] coef_reg [3];
    logic signed [COEF_BITS-1:0]      coef [9];

    always_comb begin
        coef_reg[0] = i_coef_top;
        coef_reg[1] = i_coef_mid;
        coef_reg[2] = i_coef_bot;
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
                coef[y*3+x] = coef_reg[y][c3rgb_pkg::COEF_FIELD*x +: COEF_BITS];
            end
        end
    end

    // Stage 3: 27 products.
    logic signed [PW-1:0] r3_prod [3][9];
    logic                 r3_vld;
    logic                 r3_eor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= i_view.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_eor <= i_view.eor;
            for (int ch = 0; ch < 3; ch++) begin
                for (int k = 0; k < 9; k++) begin
                    r3_prod[ch][k] <= coef[k] * $signed({1'b0, i_view.pix[k][PB*ch +: PB]});
                end
            end
        end
    end

    // Stage 4: row sums.
    logic signed [RW-1:0] r4_row [3][3];
    logic                 r4_vld;
    logic                 r4_eor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_eor <= r3_eor;
            for (int ch = 0; ch < 3; ch++) begin
                for (int y = 0; y < 3; y++) begin
                    r4_row[ch][y] <= RW'(r3_prod[ch][y*3+0]) + RW'(r3_prod[ch][y*3+1])
                                   + RW'(r3_prod[ch][y*3+2]);
                end
            end
        end
    end

    // Final sum and clamp; negative gives zero, fraction dropped, 255 at most.
    logic signed [SW-1:0] sum [3];
    logic [PB-1:0]        pix_out [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = SW'(r4_row[ch][0]) + SW'(r4_row[ch][1]) + SW'(r4_row[ch][2]);
            if (sum[ch][SW-1]) begin
                pix_out[ch] = '0;
            end else if (|sum[ch][SW-2:FB+PB]) begin
                pix_out[ch] = '1;
            end else begin
                pix_out[ch] = sum[ch][FB +: PB];
            end
        end
        o_res.vld   = r4_vld;
        o_res.eor   = r4_eor;
        o_res.red   = pix_out[0];
        o_res.green = i_grey ? '0 : pix_out[1];
        o_res.blue  = i_grey ? '0 : pix_out[2];
    end

endmodule

>>> sv/conv3x3_rgb_filter.sv
// Top level of the streaming 3x3 RGB convolution filter with zero padding.
// Holds the configuration registers and the output register with skid stage.
// Depends on c3rgb_pkg, c3rgb_line_buf, c3rgb_mac and c3rgb_ram.
//
//  Channel   Direction  Payload                                     Transfer when
//  cfg       in         i_cfg_index (register), i_cfg_data          i_cfg_valid & o_cfg_ready
//  s_axis    in         tdata red|green|blue, tuser req_type|sof    s_axis_tvalid & s_axis_tready
//  m_axis    out        tdata red|green|blue, tlast end_of_row      m_axis_tvalid & m_axis_tready
//
// The block takes one pixel per cycle while s_axis_tready is high. A transfer on s_axis
// whose result is due passes line store read, window, products, row sums, then sum and
// clamp into the output register. Results follow their pixel by image_width+1 transfers.
// The line store is one 2-row RAM read and rewritten per pixel; a read that meets the
// write of the pixel just ahead at the same entry is forwarded. Reset is synchronous
// and active low; the line store holds no reset state. When m_axis stalls, the skid
// stage takes one more result and then the whole pipeline holds, s_axis_tready low.
module conv3x3_rgb_filter #(
    parameter int MAX_WIDTH = 2048,
    parameter int COEF_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [c3rgb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [c3rgb_pkg::COEF_REG_W-1:0]      i_cfg_data,
    // Pixel input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [c3rgb_pkg::RGB_BITS-1:0]        s_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue
    input  logic [1:0]                            s_axis_tuser,  // [0] req_type, [1] start_of_frame
    // Filtered output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [c3rgb_pkg::RGB_BITS-1:0]        m_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue
    output logic                                  m_axis_tlast   // end_of_row
);

    localparam int PB = c3rgb_pkg::PIX_BITS;

    // Configuration registers. The port is always ready; the user writes only while idle, unenforced.
    logic [c3rgb_pkg::COEF_REG_W-1:0] r_coef_top;
    logic [c3rgb_pkg::COEF_REG_W-1:0] r_coef_mid;
    logic [c3rgb_pkg::COEF_REG_W-1:0] r_coef_bot;
    logic [c3rgb_pkg::IMG_W_BITS-1:0] r_image_width;
    logic                             r_grey;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top    <= c3rgb_pkg::COEF_TOP_RST;
            r_coef_mid    <= c3rgb_pkg::COEF_MID_RST;
            r_coef_bot    <= c3rgb_pkg::COEF_BOT_RST;
            r_image_width <= c3rgb_pkg::IMG_W_RST;
            r_grey        <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (c3rgb_pkg::t_cfg_idx'(i_cfg_index))
                c3rgb_pkg::CFG_COEF_TOP: r_coef_top    <= i_cfg_data;
                c3rgb_pkg::CFG_COEF_MID: r_coef_mid    <= i_cfg_data;
                c3rgb_pkg::CFG_COEF_BOT: r_coef_bot    <= i_cfg_data;
                c3rgb_pkg::CFG_IMG_W:    r_image_width <= i_cfg_data[c3rgb_pkg::IMG_W_BITS-1:0];
                c3rgb_pkg::CFG_GREY:     r_grey        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The pipeline advances as long as the skid stage is empty, so at most one
    // more result can arrive after the output register fills up.
    logic r_skid_vld;
    logic en;
    logic accept;

    assign en            = ~r_skid_vld;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid & en;

    c3rgb_pkg::t_view_bus view;
    c3rgb_pkg::t_res      res;

    c3rgb_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_accept      (accept),
        .i_req_type    (s_axis_tuser[0]),
        .i_sof         (s_axis_tuser[1]),
        .i_red         (s_axis_tdata[PB-1:0]),
        .i_green       (s_axis_tdata[2*PB-1:PB]),
        .i_blue        (s_axis_tdata[3*PB-1:2*PB]),
        .i_image_width (r_image_width),
        .i_grey        (r_grey),
        .o_view        (view)
    );

    c3rgb_mac #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_view     (view),
        .i_coef_top (r_coef_top),
        .i_coef_mid (r_coef_mid),
        .i_coef_bot (r_coef_bot),
        .i_grey     (r_grey),
        .o_res      (res)
    );

    // Output register plus one skid entry.
    logic                              r_out_vld;
    logic [c3rgb_pkg::RGB_BITS-1:0]    r_out_data;
    logic                              r_out_last;
    logic [c3rgb_pkg::RGB_BITS-1:0]    r_skid_data;
    logic                              r_skid_last;
    logic                              out_free;
    logic                              res_in;

    assign out_free = ~r_out_vld | m_axis_tready;
    assign res_in   = en & res.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= res_in;
            end
        end else if (res_in) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_out_data <= r_skid_data;
                r_out_last <= r_skid_last;
            end else begin
                r_out_data <= {res.blue, res.green, res.red};
                r_out_last <= res.eor;
            end
        end else if (res_in) begin
            r_skid_data <= {res.blue, res.green, res.red};
            r_skid_last <= res.eor;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
